FILE: design/button_press_sequence_detector_macros.svh
// Assertion helpers used by the checker file.
`ifndef BUTTON_PRESS_SEQUENCE_DETECTOR_MACROS_SVH
`define BUTTON_PRESS_SEQUENCE_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BPSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpsd assertion failed");

// Next-cycle implication, disabled while reset is held.
`define BPSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpsd assertion failed");

`endif

FILE: design/bpsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpsd_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int THR_W       = 16;
    localparam int COUNT_W     = 8;
    localparam int PAT_FIELD_W = 24;
    localparam int MASK_W      = 4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_DEBOUNCE = 3'd0;
    localparam t_cfg_idx REG_LONG     = 3'd1;
    localparam t_cfg_idx REG_GAP      = 3'd2;
    localparam t_cfg_idx REG_LEVEL    = 3'd3;
    localparam t_cfg_idx REG_MATCH_A  = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HOLD     = 2'd2,
        PH_GAP      = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        EV_SHORT = 2'd0,
        EV_LONG  = 2'd1,
        EV_END   = 2'd2
    } t_event;

    // Gathered gesture handed to the match unit
    typedef struct packed {
        logic [COUNT_W-1:0]     count;
        logic [PAT_FIELD_W-1:0] pattern;
    } t_gesture;

endpackage

`default_nettype wire

FILE: design/bpsd_match.sv
`timescale 1ns / 1ps
`default_nettype none

module bpsd_match import bpsd_pkg::*; #(
    parameter int NUM_ENTRIES = 4
) (
    input  wire logic [CFG_DATA_W-1:0] i_words [NUM_ENTRIES],
    input  wire t_gesture              i_gesture,
    output logic [MASK_W-1:0]          o_mask
);

    // Compare every entry against the gathered size and pattern; zero size never matches
    always_comb begin
        o_mask = '0;
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            if ((i_words[k][COUNT_W-1:0] != '0) &&
                (i_words[k][COUNT_W-1:0] == i_gesture.count) &&
                (i_words[k][CFG_DATA_W-1:COUNT_W] == i_gesture.pattern)) begin
                o_mask[k] = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/button_press_sequence_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// Button press sequence detector.
// Input channel (i_in_valid / o_in_ready) carries one pin sample word per tick.
// Output channel (o_out_valid / i_out_ready) carries at most one event word per
// sample: short press, long press, or gesture end with the entry match mask.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_wdata); write
// only while no sample is in flight.
// Path: an accepted sample passes through the input register, then one pass of
// phase/timer logic into the output register, where its event word waits.
// Throughput: one sample per cycle while the receiver does not stall; the phase
// and tick counter update is a single pass of compare and increment logic.
// Reset (synchronous, active low) empties both registers, puts the tracker in
// idle with counts and pattern cleared, marks the button as released and loads
// the register defaults.
// When the receiver stalls, hold the event in the output register; the input
// register still takes one more word, then o_in_ready drops until the event
// leaves.
module button_press_sequence_detector import bpsd_pkg::*; #(
    parameter int NUM_ENTRIES   = 4,
    parameter int PATTERN_WIDTH = 24,
    parameter int TICK_WIDTH    = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_pin_level,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [1:0]                  o_event_kind,
    output logic [COUNT_W-1:0]          o_press_count,
    output logic [PAT_FIELD_W-1:0]      o_press_pattern,
    output logic [MASK_W-1:0]           o_match_mask
);

    localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

    // Clamp a 16-bit threshold to the tick counter range so each phase ends
    function automatic logic [TICK_WIDTH-1:0] clamp_thr(input logic [THR_W-1:0] thr);
        logic [31:0] wide;
        wide = 32'(thr);
        if (wide > 32'(TICK_MAX)) begin
            return TICK_MAX;
        end
        return TICK_WIDTH'(wide);
    endfunction

    // Configuration registers
    logic [THR_W-1:0]      r_debounce;
    logic [THR_W-1:0]      r_long;
    logic [THR_W-1:0]      r_gap;
    logic                  r_level;
    logic [CFG_DATA_W-1:0] r_match [NUM_ENTRIES];

    // Input register
    logic r_in_valid;
    logic r_in_pin;

    // Tracker state
    t_phase                  r_phase, n_phase;
    logic [TICK_WIDTH-1:0]   r_tick, n_tick;
    logic [COUNT_W-1:0]      r_presses, n_presses;
    logic [PATTERN_WIDTH-1:0] r_pattern, n_pattern;
    logic                    r_was_active;

    // Output register
    logic                   r_out_valid;
    t_event                 r_out_kind;
    logic [COUNT_W-1:0]     r_out_count;
    logic [PAT_FIELD_W-1:0] r_out_pattern;
    logic [MASK_W-1:0]      r_out_mask;

    logic                     w_adv;
    logic                     w_step;
    logic                     w_active;
    logic                     w_rising;
    logic [TICK_WIDTH-1:0]    w_tick_inc;
    logic                     w_deb_done;
    logic                     w_long_hit;
    logic                     w_gap_done;
    logic                     w_res_valid;
    t_event                   w_res_kind;
    logic [COUNT_W-1:0]       w_presses_rec;
    logic [PATTERN_WIDTH-1:0] w_pattern_rec;
    t_gesture                 w_gesture;
    logic [MASK_W-1:0]        w_mask;

    // Handshake: the output register frees up when empty or being taken
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_step     = r_in_valid && w_adv;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= THR_W'(1);
            r_long     <= THR_W'(25);
            r_gap      <= THR_W'(25);
            r_level    <= 1'b0;
            for (int k = 0; k < NUM_ENTRIES; k++) begin
                r_match[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE: r_debounce <= i_cfg_wdata[THR_W-1:0];
                REG_LONG:     r_long     <= i_cfg_wdata[THR_W-1:0];
                REG_GAP:      r_gap      <= i_cfg_wdata[THR_W-1:0];
                REG_LEVEL:    r_level    <= i_cfg_wdata[0];
                default: begin
                    // Match entries; indexes past the built entries are dropped
                    for (int k = 0; k < NUM_ENTRIES; k++) begin
                        if (i_cfg_idx == CFG_IDX_W'(REG_MATCH_A + k)) begin
                            r_match[k] <= i_cfg_wdata;
                        end
                    end
                end
            endcase
        end
    end

    // Input register: take a word when free, drop it once processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_pin <= i_pin_level;
        end
    end

    // Level decode and timer compares
    assign w_active   = (r_in_pin == r_level);
    assign w_rising   = w_active && !r_was_active;
    assign w_tick_inc = (r_tick == TICK_MAX) ? r_tick : r_tick + TICK_WIDTH'(1);
    assign w_deb_done = (w_tick_inc >= clamp_thr(r_debounce));
    assign w_long_hit = (w_tick_inc >= clamp_thr(r_long));
    assign w_gap_done = (w_tick_inc >= clamp_thr(r_gap));

    // Event decision
    always_comb begin
        w_res_valid = 1'b0;
        w_res_kind  = EV_SHORT;
        unique case (r_phase)
            PH_IDLE: begin
                w_res_valid = 1'b0;
            end
            PH_GAP: begin
                if (!w_rising && w_gap_done) begin
                    w_res_valid = 1'b1;
                    w_res_kind  = EV_END;
                end
            end
            PH_DEBOUNCE: begin
                // Release seen at the debounce check: glitch, counted as short
                if (w_deb_done && !w_active) begin
                    w_res_valid = 1'b1;
                    w_res_kind  = EV_SHORT;
                end
            end
            PH_HOLD: begin
                if (!w_active) begin
                    w_res_valid = 1'b1;
                    w_res_kind  = w_long_hit ? EV_LONG : EV_SHORT;
                end
            end
            default: begin
                w_res_valid = 1'b0;
            end
        endcase
    end

    // Press record: saturating count, pattern bit for long presses in range
    always_comb begin
        w_presses_rec = (r_presses == '1) ? r_presses : r_presses + COUNT_W'(1);
        w_pattern_rec = r_pattern;
        for (int i = 0; i < PATTERN_WIDTH; i++) begin
            if ((w_res_kind == EV_LONG) && (r_presses == COUNT_W'(i))) begin
                w_pattern_rec[i] = 1'b1;
            end
        end
    end

    // Next state
    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_presses = r_presses;
        n_pattern = r_pattern;
        unique case (r_phase)
            PH_IDLE: begin
                if (w_rising) begin
                    n_phase = PH_DEBOUNCE;
                    n_tick  = '0;
                end
            end
            PH_GAP: begin
                if (w_rising) begin
                    n_phase = PH_DEBOUNCE;
                    n_tick  = '0;
                end else if (w_gap_done) begin
                    n_phase   = PH_IDLE;
                    n_tick    = '0;
                    n_presses = '0;
                    n_pattern = '0;
                end else begin
                    n_tick = w_tick_inc;
                end
            end
            PH_DEBOUNCE, PH_HOLD: begin
                n_tick = w_tick_inc;
                if (w_res_valid) begin
                    n_phase   = PH_GAP;
                    n_tick    = '0;
                    n_presses = w_presses_rec;
                    n_pattern = w_pattern_rec;
                end else if (r_phase == PH_DEBOUNCE && w_deb_done) begin
                    n_phase = PH_HOLD;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick       <= '0;
            r_presses    <= '0;
            r_pattern    <= '0;
            r_was_active <= 1'b0;
        end else if (w_step) begin
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_presses    <= n_presses;
            r_pattern    <= n_pattern;
            r_was_active <= w_active;
        end
    end

    // Entry match on the gesture as it stands before clearing
    assign w_gesture.count   = r_presses;
    assign w_gesture.pattern = PAT_FIELD_W'(r_pattern);

    bpsd_match #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_match (
        .i_words   (r_match),
        .i_gesture (w_gesture),
        .o_mask    (w_mask)
    );

    // Output register: load on a processed word, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_step && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res_valid) begin
            r_out_kind <= w_res_kind;
            if (w_res_kind == EV_END) begin
                r_out_count   <= r_presses;
                r_out_pattern <= PAT_FIELD_W'(r_pattern);
                r_out_mask    <= w_mask;
            end else begin
                r_out_count   <= w_presses_rec;
                r_out_pattern <= PAT_FIELD_W'(w_pattern_rec);
                r_out_mask    <= '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_kind    = r_out_kind;
    assign o_press_count   = r_out_count;
    assign o_press_pattern = r_out_pattern;
    assign o_match_mask    = r_out_mask;

endmodule

`default_nettype wire

FILE: design/bpsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "button_press_sequence_detector_macros.svh"

module bpsd_checker import bpsd_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [1:0]             i_event_kind,
    input wire logic [COUNT_W-1:0]     i_press_count,
    input wire logic [PAT_FIELD_W-1:0] i_press_pattern,
    input wire logic [MASK_W-1:0]      i_match_mask
);

    // A stalled event word holds
    `BPSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_event_kind) && $stable(i_press_count) && $stable(i_match_mask))

    // Only a gesture end carries a match mask
    `BPSD_ASSERT_IMPL(a_mask_on_end, i_clk, i_rst_n, i_out_valid && (i_event_kind != EV_END), i_match_mask == '0)

    // Every event follows at least one press
    `BPSD_ASSERT_IMPL(a_count_nonzero, i_clk, i_rst_n, i_out_valid, i_press_count != '0)

    // A long first press sets the lowest pattern bit
    `BPSD_ASSERT_IMPL(a_first_long, i_clk, i_rst_n, i_out_valid && (i_event_kind == EV_LONG) && (i_press_count == COUNT_W'(1)), i_press_pattern[0])

endmodule

bind button_press_sequence_detector bpsd_checker u_bpsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .i_event_kind    (o_event_kind),
    .i_press_count   (o_press_count),
    .i_press_pattern (o_press_pattern),
    .i_match_mask    (o_match_mask)
);

`default_nettype wire
